// ----- src/cdes_pkg.sv -----
// Shared types, constants and register map of the drive enable sequencer.
`timescale 1ns / 1ps
package cdes_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] HoldReset    = 16'd5;
  localparam logic [15:0] TimeoutReset = 16'd50;

  localparam logic [15:0] CwNone     = 16'h0000;
  localparam logic [15:0] CwShutdown = 16'h0006;
  localparam logic [15:0] CwSwitchOn = 16'h0007;
  localparam logic [15:0] CwEnableOp = 16'h000F;
  localparam logic [15:0] CwFaultRst = 16'h0080;

  localparam logic [15:0] SwMask  = 16'h006F;
  localparam logic [15:0] SwFault = 16'h0008;

  localparam logic [6:0] SwNotReady   = 7'h00;
  localparam logic [6:0] SwSwOnDis    = 7'h40;
  localparam logic [6:0] SwReady      = 7'h21;
  localparam logic [6:0] SwSwitchedOn = 7'h23;
  localparam logic [6:0] SwOpEnabled  = 7'h27;
  localparam logic [6:0] SwQuickStop  = 7'h07;
  localparam logic [6:0] SwFaultReact = 7'h0F;
  localparam logic [6:0] SwFaultState = 7'h08;

  localparam logic [3:0] DsNotReady   = 4'd0;
  localparam logic [3:0] DsSwOnDis    = 4'd1;
  localparam logic [3:0] DsReady      = 4'd2;
  localparam logic [3:0] DsSwitchedOn = 4'd3;
  localparam logic [3:0] DsOpEnabled  = 4'd4;
  localparam logic [3:0] DsQuickStop  = 4'd5;
  localparam logic [3:0] DsFaultReact = 4'd6;
  localparam logic [3:0] DsFault      = 4'd7;
  localparam logic [3:0] DsUnknown    = 4'd8;

  localparam logic RegHold    = 1'b0;
  localparam logic RegTimeout = 1'b1;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_RUN_OFF,
    CLS_FAULT,
    CLS_NORMAL
  } cls_e;

  typedef enum logic [2:0] {
    ST_SEND_SHUTDOWN,
    ST_WAIT_READY,
    ST_SEND_SWITCH_ON,
    ST_WAIT_SWITCHED_ON,
    ST_SEND_ENABLE_OP,
    ST_WAIT_OP_ENABLED,
    ST_OP_ENABLED
  } stage_e;

  typedef struct packed {
    logic [15:0]        status_word;
    logic               run_enable;
    logic signed [31:0] set_position;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        control_word;
    logic signed [31:0] position_out;
    logic [2:0]         stage_out;
    logic [3:0]         drive_state;
  } out_item_t;

  typedef struct packed {
    cls_e               cls;
    logic [6:0]         masked_status;
    logic [3:0]         drive_state;
    logic signed [31:0] position;
  } cmd_t;

  typedef struct packed {
    stage_e stage;
    logic   step;
  } seq_stat_t;

endpackage

// ----- src/cdes_fifo.sv -----
// Small register queue with a registered head entry.
`timescale 1ns / 1ps
module cdes_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- src/cdes_front.sv -----
// Front end: accepts ticks, decodes the drive state and classifies each tick.
`timescale 1ns / 1ps
module cdes_front (
  input  logic              push_i,
  input  cdes_pkg::in_item_t item_i,
  input  logic              q_full_i,
  output logic              full_o,
  output logic              q_push_o,
  output cdes_pkg::cmd_t    cmd_o
);
  import cdes_pkg::*;

  logic [15:0] masked;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;
  assign masked   = item_i.status_word & SwMask;

  always_comb begin
    cmd_o.masked_status = masked[6:0];
    cmd_o.position      = item_i.set_position;
    if (item_i.status_word == '0) begin
      cmd_o.cls = CLS_ZERO;
    end else if (!item_i.run_enable) begin
      cmd_o.cls = CLS_RUN_OFF;
    end else if ((item_i.status_word & SwFault) != '0) begin
      cmd_o.cls = CLS_FAULT;
    end else begin
      cmd_o.cls = CLS_NORMAL;
    end
    unique case (masked[6:0])
      SwNotReady:   cmd_o.drive_state = DsNotReady;
      SwSwOnDis:    cmd_o.drive_state = DsSwOnDis;
      SwReady:      cmd_o.drive_state = DsReady;
      SwSwitchedOn: cmd_o.drive_state = DsSwitchedOn;
      SwOpEnabled:  cmd_o.drive_state = DsOpEnabled;
      SwQuickStop:  cmd_o.drive_state = DsQuickStop;
      SwFaultReact: cmd_o.drive_state = DsFaultReact;
      SwFaultState: cmd_o.drive_state = DsFault;
      default:      cmd_o.drive_state = DsUnknown;
    endcase
  end

endmodule

// ----- src/cdes_back.sv -----
// Back end: the enable sequence state machine with hold and timeout counters.
`timescale 1ns / 1ps
module cdes_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         hold_cycles_i,
  input  logic [15:0]         timeout_cycles_i,
  input  cdes_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  input  logic                res_full_i,
  output logic                cmd_pop_o,
  output logic                res_push_o,
  output cdes_pkg::out_item_t res_o,
  output cdes_pkg::seq_stat_t stat_o
);
  import cdes_pkg::*;

  stage_e      stage_q, stage_d;
  logic [15:0] hold_q, hold_d;
  logic [15:0] tmo_q, tmo_d;
  logic        step;
  logic [15:0] cw;

  assign step       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = step;
  assign res_push_o = step;

  always_comb begin
    stage_d = stage_q;
    hold_d  = hold_q;
    tmo_d   = tmo_q;
    unique case (cmd_i.cls)
      CLS_ZERO: ;
      CLS_RUN_OFF: begin
        stage_d = ST_WAIT_READY;
        hold_d  = '0;
        tmo_d   = timeout_cycles_i;
      end
      CLS_FAULT: begin
        stage_d = ST_SEND_SHUTDOWN;
        hold_d  = '0;
        tmo_d   = '0;
      end
      default: begin
        unique case (stage_q)
          ST_SEND_SHUTDOWN, ST_SEND_SWITCH_ON, ST_SEND_ENABLE_OP: begin
            hold_d  = hold_cycles_i;
            tmo_d   = timeout_cycles_i;
            stage_d = stage_e'(stage_q + 3'd1);
          end
          ST_WAIT_READY, ST_WAIT_SWITCHED_ON, ST_WAIT_OP_ENABLED: begin
            if (hold_q != '0) begin
              hold_d = hold_q - 16'd1;
            end else if ((stage_q == ST_WAIT_READY && cmd_i.masked_status == SwReady) ||
                         (stage_q == ST_WAIT_SWITCHED_ON &&
                          cmd_i.masked_status == SwSwitchedOn) ||
                         (stage_q == ST_WAIT_OP_ENABLED &&
                          cmd_i.masked_status == SwOpEnabled)) begin
              stage_d = stage_e'(stage_q + 3'd1);
            end else if (tmo_q != '0) begin
              tmo_d = tmo_q - 16'd1;
            end else begin
              stage_d = stage_e'(stage_q - 3'd1);
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.cls)
      CLS_ZERO:    cw = CwNone;
      CLS_RUN_OFF: cw = CwShutdown;
      CLS_FAULT:   cw = CwFaultRst;
      default: begin
        unique case (stage_q)
          ST_SEND_SHUTDOWN, ST_WAIT_READY:        cw = CwShutdown;
          ST_SEND_SWITCH_ON, ST_WAIT_SWITCHED_ON: cw = CwSwitchOn;
          default:                                cw = CwEnableOp;
        endcase
      end
    endcase
  end

  always_comb begin
    res_o.control_word = cw;
    res_o.position_out = cmd_i.position;
    res_o.stage_out    = stage_d;
    res_o.drive_state  = cmd_i.drive_state;
    stat_o.stage       = stage_q;
    stat_o.step        = step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_SEND_SHUTDOWN;
      hold_q  <= '0;
      tmo_q   <= '0;
    end else if (step) begin
      stage_q <= stage_d;
      hold_q  <= hold_d;
      tmo_q   <= tmo_d;
    end
  end

endmodule

// ----- src/cia402_drive_enable_sequencer_unit.sv -----
// Top level of the CiA402 drive enable sequencer.
//
// Each input transfer is one cyclic tick: statusword, run request and target
// position, written with push while full is low. Each tick yields exactly one
// result (controlword, forwarded position, stage and decoded drive state),
// read from the result queue with pop while empty is low.
// A front end classifies the tick into a small queue; the back end runs the
// enable sequence state machine and writes the result queue.
// A tick accepted into an idle block is registered in the front queue and then
// moved by the back end into the result queue, from where it can be popped.
// One tick per cycle is sustained while the receiver keeps popping; the back end
// state machine takes one queued tick per cycle whenever the result queue has room.
// When the receiver stops popping, the result queue fills, the back end
// stalls, and full rises once the front queue is also full.
// Reset empties both queues, returns the sequencer to the shutdown send step
// with cleared counters, and sets hold_cycles to 5 and timeout_cycles to 50.
// The two registers sit at byte addresses 0 and 4 of the APB port and should
// be written only while the block is idle.
`timescale 1ns / 1ps
module cia402_drive_enable_sequencer_unit #(
  parameter int unsigned QueueDepth = cdes_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  cdes_pkg::in_item_t  in_item_i,
  input  logic                pop,
  output logic                empty,
  output cdes_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cdes_pkg::*;

  logic [15:0] hold_cycles_q;
  logic [15:0] timeout_cycles_q;
  logic        cfg_write;

  cmd_t        front_cmd, mid_cmd;
  logic        mid_push, mid_full, mid_empty, mid_pop;
  out_item_t   back_res;
  logic        res_push, res_full;
  seq_stat_t   seq_stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      RegHold:    prdata = {16'd0, hold_cycles_q};
      RegTimeout: prdata = {16'd0, timeout_cycles_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles_q    <= HoldReset;
      timeout_cycles_q <= TimeoutReset;
    end else if (cfg_write) begin
      if (paddr[2] == RegHold) begin
        hold_cycles_q <= pwdata[15:0];
      end else begin
        timeout_cycles_q <= pwdata[15:0];
      end
    end
  end

  cdes_front u_front (
    .push_i   (push),
    .item_i   (in_item_i),
    .q_full_i (mid_full),
    .full_o   (full),
    .q_push_o (mid_push),
    .cmd_o    (front_cmd)
  );

  cdes_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (QueueDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (front_cmd),
    .pop_i   (mid_pop),
    .data_o  (mid_cmd),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  cdes_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hold_cycles_i    (hold_cycles_q),
    .timeout_cycles_i (timeout_cycles_q),
    .cmd_i            (mid_cmd),
    .cmd_valid_i      (!mid_empty),
    .res_full_i       (res_full),
    .cmd_pop_o        (mid_pop),
    .res_push_o       (res_push),
    .res_o            (back_res),
    .stat_o           (seq_stat)
  );

  cdes_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .full_o  (res_full),
    .empty_o (empty)
  );

  // A tick accepted into an idle block passes through the front queue into the result queue and can then be popped.
  a_idle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && mid_empty && empty |=> ##1 !empty)
    else $error("accepted tick did not reach the result queue");

  // The sequencer stage only moves when a tick is processed.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_stat.step |=> $stable(seq_stat.stage))
    else $error("sequencer stage changed without a tick");

  // The back end never writes a result into a full result queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full && !mid_empty)
    else $error("result written while the result queue was full");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the CiA402 drive enable sequencer.
`timescale 1ns / 1ps
module tb;
  import cdes_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        pop = 1'b0;
  logic        empty;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cia402_drive_enable_sequencer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the sequencer state and its timing registers.
  stage_e      seq_stage = ST_SEND_SHUTDOWN;
  logic [15:0] hold_left = '0;
  logic [15:0] wait_left = '0;
  logic [15:0] cfg_hold = HoldReset;
  logic [15:0] cfg_timeout = TimeoutReset;

  in_item_t    tick_q[$];
  out_item_t   reply_q[$];
  int unsigned mismatch_count = 0;
  logic        tick_taken = 1'b0;
  int unsigned idle_odds = 0;
  logic        quiet = 1'b0;
  int unsigned send_gap = 0;
  int unsigned pop_gap = 0;

  int unsigned hold_set[11] = '{0, 1, 2, 65535, 5, 0, 3, 65535, 1, 0, 4};
  int unsigned tout_set[11] = '{0, 3, 6, 65535, 50, 65535, 1, 0, 9, 2, 0};

  function automatic logic [3:0] drive_code(logic [6:0] seen);
    case (seen)
      SwNotReady:   return DsNotReady;
      SwSwOnDis:    return DsSwOnDis;
      SwReady:      return DsReady;
      SwSwitchedOn: return DsSwitchedOn;
      SwOpEnabled:  return DsOpEnabled;
      SwQuickStop:  return DsQuickStop;
      SwFaultReact: return DsFaultReact;
      SwFaultState: return DsFault;
      default:      return DsUnknown;
    endcase
  endfunction

  function automatic void load_step(stage_e nxt);
    hold_left = cfg_hold;
    wait_left = cfg_timeout;
    seq_stage = nxt;
  endfunction

  function automatic void await_state(logic [6:0] seen, logic [6:0] want, stage_e retry,
                                      stage_e nxt);
    if (hold_left != 0) hold_left = hold_left - 16'd1;
    else if (seen == want) seq_stage = nxt;
    else if (wait_left != 0) wait_left = wait_left - 16'd1;
    else seq_stage = retry;
  endfunction

  function automatic out_item_t advance_sequencer(in_item_t it);
    logic [6:0] seen;
    out_item_t  r;
    seen = it.status_word[6:0] & SwMask[6:0];
    r.position_out = it.set_position;
    r.drive_state = drive_code(seen);
    if (it.status_word == 16'h0000) begin
      r.control_word = CwNone;
    end else if (!it.run_enable) begin
      r.control_word = CwShutdown;
      seq_stage = ST_WAIT_READY;
      hold_left = '0;
      wait_left = cfg_timeout;
    end else if ((it.status_word & SwFault) != 0) begin
      r.control_word = CwFaultRst;
      seq_stage = ST_SEND_SHUTDOWN;
      hold_left = '0;
      wait_left = '0;
    end else begin
      case (seq_stage)
        ST_SEND_SHUTDOWN: begin
          r.control_word = CwShutdown;
          load_step(ST_WAIT_READY);
        end
        ST_WAIT_READY: begin
          r.control_word = CwShutdown;
          await_state(seen, SwReady, ST_SEND_SHUTDOWN, ST_SEND_SWITCH_ON);
        end
        ST_SEND_SWITCH_ON: begin
          r.control_word = CwSwitchOn;
          load_step(ST_WAIT_SWITCHED_ON);
        end
        ST_WAIT_SWITCHED_ON: begin
          r.control_word = CwSwitchOn;
          await_state(seen, SwSwitchedOn, ST_SEND_SWITCH_ON, ST_SEND_ENABLE_OP);
        end
        ST_SEND_ENABLE_OP: begin
          r.control_word = CwEnableOp;
          load_step(ST_WAIT_OP_ENABLED);
        end
        ST_WAIT_OP_ENABLED: begin
          r.control_word = CwEnableOp;
          await_state(seen, SwOpEnabled, ST_SEND_ENABLE_OP, ST_OP_ENABLED);
        end
        default: r.control_word = CwEnableOp;
      endcase
    end
    r.stage_out = seq_stage;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(negedge clk_i) begin : drive_ports
    logic     push_nxt;
    logic     pop_nxt;
    in_item_t item_nxt;
    push_nxt = push;
    pop_nxt = pop;
    item_nxt = in_item;
    if (rst_n) begin
      if (!push || tick_taken) begin
        push_nxt = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
        end else if (tick_q.size() != 0) begin
          if (!quiet && $urandom_range(0, 15) < idle_odds) begin
            send_gap = $urandom_range(0, 6);
          end else begin
            push_nxt = 1'b1;
            item_nxt = tick_q.pop_front();
          end
        end
      end
      if (pop_gap != 0) begin
        pop_nxt = 1'b0;
        pop_gap--;
      end else if (!quiet && $urandom_range(0, 15) < idle_odds) begin
        pop_nxt = 1'b0;
        pop_gap = $urandom_range(0, 6);
      end else begin
        pop_nxt = 1'b1;
      end
    end
    push <= push_nxt;
    pop <= pop_nxt;
    in_item <= item_nxt;
  end

  always @(posedge clk_i) begin : watch_ports
    out_item_t want;
    if (!rst_n) begin
      tick_taken = 1'b0;
    end else begin
      tick_taken = push && !full;
      if (tick_taken) reply_q.push_back(advance_sequencer(in_item));
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          note_mismatch("result transfer with nothing expected",
                        32'(out_item.control_word), 32'd0);
        end else begin
          want = reply_q.pop_front();
          if (out_item.control_word !== want.control_word)
            note_mismatch("control_word", 32'(out_item.control_word),
                          32'(want.control_word));
          if (out_item.position_out !== want.position_out)
            note_mismatch("position_out", out_item.position_out, want.position_out);
          if (out_item.stage_out !== want.stage_out)
            note_mismatch("stage_out", 32'(out_item.stage_out), 32'(want.stage_out));
          if (out_item.drive_state !== want.drive_state)
            note_mismatch("drive_state", 32'(out_item.drive_state),
                          32'(want.drive_state));
        end
      end
    end
  end

  task automatic reg_check(logic idx, logic [15:0] want);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== want) note_mismatch("register read", 32'(prdata[15:0]), 32'(want));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timing(logic [15:0] hold, logic [15:0] tout);
    for (int i = 0; i < 2; i++) begin
      @(negedge clk_i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {(i == 0) ? RegHold : RegTimeout, 2'b00};
      pwdata <= {16'h0000, (i == 0) ? hold : tout};
      @(negedge clk_i);
      penable <= 1'b1;
      @(negedge clk_i);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end
    cfg_hold = hold;
    cfg_timeout = tout;
    reg_check(RegHold, hold);
    reg_check(RegTimeout, tout);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || push || reply_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void add_tick(logic [15:0] sw, logic run, logic [31:0] pos);
    in_item_t it;
    it.status_word = sw;
    it.run_enable = run;
    it.set_position = pos;
    tick_q.push_back(it);
  endfunction

  function automatic logic [15:0] dress_status(logic [6:0] base);
    logic [15:0] r;
    r = 16'($urandom);
    return (r & ~SwMask) | 16'(base);
  endfunction

  function automatic void add_noise();
    logic [15:0] sw;
    sw = 16'($urandom);
    if ($urandom_range(0, 9) == 0) sw = '0;
    add_tick(sw, 1'($urandom), $urandom);
  endfunction

  // A drive that walks ready, switched on and operation enabled for random spans.
  function automatic void add_drive_run();
    int          span;
    logic [6:0]  walk[3];
    walk = '{SwReady, SwSwitchedOn, SwOpEnabled};
    span = cfg_hold + cfg_timeout + 4;
    if (span > 40) span = 40;
    case ($urandom_range(0, 3))
      0: add_tick(dress_status(SwSwOnDis), 1'b0, $urandom);
      1: add_tick(dress_status(SwFaultState), 1'b1, $urandom);
      default: ;
    endcase
    foreach (walk[k]) begin
      repeat ($urandom_range(1, span)) begin
        if ($urandom_range(0, 19) == 0) add_noise();
        else add_tick(dress_status(walk[k]), 1'b1, $urandom);
      end
    end
  endfunction

  initial begin : run_test
    int n;
    repeat (11) @(negedge clk_i);
    rst_n <= 1'b1;
    reg_check(RegHold, HoldReset);
    reg_check(RegTimeout, TimeoutReset);
    idle_odds = 4;

    add_tick(16'h0000, 1'b1, 32'h7FFF_FFFF);
    add_tick(16'h0000, 1'b0, 32'h8000_0000);
    add_tick(16'hFFFF, 1'b0, 32'h0000_0000);
    add_tick(16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    add_tick(16'(SwFaultState), 1'b1, 32'h0000_0001);
    add_tick(16'(SwFaultReact), 1'b1, 32'h5555_AAAA);
    add_tick(16'(SwQuickStop), 1'b1, 32'hAAAA_5555);
    add_tick(16'(SwSwOnDis), 1'b1, 32'h0000_0002);
    add_tick(16'h0010, 1'b1, 32'h0000_0003);
    add_tick(16'h0001, 1'b1, 32'h0000_0004);
    wait_drained();

    set_timing(16'd0, 16'd1);
    add_tick(16'h8000 | 16'(SwReady), 1'b0, 32'h0000_0005);
    add_tick(16'(SwSwOnDis), 1'b1, 32'h0000_0006);
    add_tick(16'(SwSwOnDis), 1'b1, 32'h0000_0007);
    add_tick(16'(SwReady), 1'b1, 32'h0000_0008);
    add_tick(16'(SwReady), 1'b1, 32'h0000_0009);
    add_tick(16'(SwSwitchedOn), 1'b1, 32'h0000_000A);
    add_tick(16'(SwSwitchedOn), 1'b1, 32'h0000_000B);
    add_tick(16'(SwOpEnabled), 1'b1, 32'h0000_000C);
    add_tick(16'(SwOpEnabled), 1'b1, 32'h0000_000D);
    add_tick(16'(SwOpEnabled), 1'b1, 32'h0000_000E);
    add_tick(16'h0000, 1'b1, 32'h0000_000F);
    add_tick(16'(SwOpEnabled), 1'b0, 32'h0000_0010);
    add_tick(16'h0028, 1'b1, 32'h0000_0011);
    wait_drained();

    for (int p = 0; p < 11; p++) begin
      set_timing(16'(hold_set[p]), 16'(tout_set[p]));
      idle_odds = $urandom_range(0, 6);
      quiet = (p == 10);
      n = (hold_set[p] == 65535 || tout_set[p] == 65535) ? 40 : 160;
      while (tick_q.size() < n) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) add_noise();
        end else begin
          add_drive_run();
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
